// ===== hw/rtl/sha1_block_compression_assert.svh =====
// Assertion macros shared by the SHA-1 compression RTL.
// Expects i_clk and i_rst_n in the scope of each use.
`ifndef SHA1_BLOCK_COMPRESSION_ASSERT_SVH
`define SHA1_BLOCK_COMPRESSION_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define SHA1C_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sha1c assertion failed");

// Next-cycle implication, checked outside reset
`define SHA1C_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sha1c assertion failed");

`endif

// ===== hw/rtl/sha1c_pkg.sv =====
// Package for the SHA-1 block compression engine: payload types,
// initial chaining value, round key resets and rotate helpers. No dependencies.
`default_nettype none

package sha1c_pkg;

    localparam int WORD_W      = 32;
    localparam int NUM_CHAIN   = 5;
    localparam int NUM_KEYS    = 4;
    localparam int APB_ADDR_W  = 4;
    localparam int QUEUE_DEPTH = 2;

    typedef logic [WORD_W-1:0] t_word;

    localparam t_word INIT_CHAIN [NUM_CHAIN] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };
    localparam t_word KEY_RESET [NUM_KEYS] = '{
        32'h5A827999, 32'h6ED9EBA1, 32'h8F1BBCDC, 32'hCA62C1D6
    };

    // Round numbering
    localparam logic [3:0] WORD_FIRST  = 4'd0;
    localparam logic [3:0] WORD_LAST   = 4'd15;
    localparam logic [6:0] ROUND_SCHED = 7'd16;
    localparam logic [6:0] ROUND_B1    = 7'd20;
    localparam logic [6:0] ROUND_B2    = 7'd40;
    localparam logic [6:0] ROUND_B3    = 7'd60;
    localparam logic [6:0] ROUND_LAST  = 7'd79;
    localparam logic [2:0] DIG_LAST    = 3'd4;

    // Input word on the message channel
    typedef struct packed {
        t_word message_word;
        logic  start_message;
    } t_msg_word;

    // Result word on the digest channel
    typedef struct packed {
        t_word      digest_word;
        logic [2:0] digest_index;
        logic       digest_last;
    } t_dig_word;

    // Classified word passed from front to back
    typedef struct packed {
        t_word      word;
        logic       start;
        logic [3:0] idx;
    } t_blk_item;

    function automatic t_word rotl1(input t_word x);
        return {x[WORD_W-2:0], x[WORD_W-1]};
    endfunction

    function automatic t_word rotl5(input t_word x);
        return {x[WORD_W-6:0], x[WORD_W-1:WORD_W-5]};
    endfunction

    function automatic t_word rotl30(input t_word x);
        return {x[1:0], x[WORD_W-1:2]};
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/sha1c_stream_if.sv =====
// Valid/ready stream interfaces for the message and digest channels.
// Depends on sha1c_pkg for the payload types.
`default_nettype none

interface sha1c_msg_if import sha1c_pkg::*; ();
    logic      valid;
    logic      ready;
    t_msg_word data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface sha1c_dig_if import sha1c_pkg::*; ();
    logic      valid;
    logic      ready;
    t_dig_word data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/sha1_block_compression.sv =====
// Top level of the SHA-1 block compression engine: round key registers on APB,
// front end, queue and round engine. Depends on sha1c_pkg, the stream interfaces,
// sha1c_front, sha1c_queue and sha1c_back.
//
//   Channel   Dir   Handshake       Payload
//   i_msg     in    valid/ready     message_word[31:0], start_message
//   o_dig     out   valid/ready     digest_word[31:0], digest_index[2:0], digest_last
//   APB       in    psel/penable    round_key_0..3 at byte addresses 0, 4, 8, 12
//
// For a block of 16 words, rounds 0..15 run one per cycle as words leave the
// queue, 64 more rounds follow on the schedule shift line, a final state adds into
// the chaining value and the digest output register is loaded with the five
// digest words in turn. All rounds share the single round adder chain.
// Reset is synchronous: keys and chaining value return to their standard values.
// While the engine runs rounds, adds or emits, words fill the queue and then stall.
`default_nettype none

module sha1_block_compression import sha1c_pkg::*; #(
    parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    sha1c_msg_if.sink                  i_msg,
    sha1c_dig_if.source                o_dig,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [WORD_W-1:0]     pwdata,
    output logic      [WORD_W-1:0]     prdata,
    output logic                       pready
);

    t_word     r_key [NUM_KEYS];
    logic      cfg_wr;
    t_blk_item push_item;
    logic      push_valid;
    logic      push_ready;
    t_blk_item pop_item;
    logic      pop_valid;
    logic      pop_ready;

    // Write round keys in the APB access phase
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = r_key[paddr[3:2]];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_KEYS; i++) begin
                r_key[i] <= KEY_RESET[i];
            end
        end else if (cfg_wr) begin
            r_key[paddr[3:2]] <= pwdata;
        end
    end

    sha1c_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_msg        (i_msg),
        .o_item       (push_item),
        .o_item_valid (push_valid),
        .i_item_ready (push_ready)
    );

    sha1c_queue #(
        .DEPTH (QUEUE_DEPTH_P)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_item  (push_item),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .o_pop_item   (pop_item),
        .o_pop_valid  (pop_valid),
        .i_pop_ready  (pop_ready)
    );

    sha1c_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_keys       (r_key),
        .i_item       (pop_item),
        .i_item_valid (pop_valid),
        .o_item_ready (pop_ready),
        .o_dig        (o_dig)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/sha1c_front.sv =====
// Front end: accepts message words, tracks the position within the block.
// Depends on sha1c_pkg and sha1c_msg_if.
`default_nettype none

module sha1c_front import sha1c_pkg::*; (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    sha1c_msg_if.sink      i_msg,
    output t_blk_item      o_item,
    output logic           o_item_valid,
    input  wire logic      i_item_ready
);

    logic [3:0] r_word_count;
    logic [3:0] n_word_count;
    logic [3:0] cur_idx;
    logic       accept;

    // Pass words straight into the queue; a start restarts the block
    assign i_msg.ready  = i_item_ready;
    assign o_item_valid = i_msg.valid;
    assign accept       = i_msg.valid && i_item_ready;
    assign cur_idx      = i_msg.data.start_message ? WORD_FIRST : r_word_count;

    always_comb begin
        o_item.word  = i_msg.data.message_word;
        o_item.start = i_msg.data.start_message;
        o_item.idx   = cur_idx;
    end

    // Advance the word position, wrapping after sixteen
    assign n_word_count = accept ? (cur_idx + 4'd1) : r_word_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word_count <= WORD_FIRST;
        end else begin
            r_word_count <= n_word_count;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/sha1c_queue.sv =====
// Short FIFO that decouples the front end from the round engine.
// Depends on sha1c_pkg for the item type.
`default_nettype none

module sha1c_queue import sha1c_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_blk_item i_push_item,
    input  wire logic      i_push_valid,
    output logic           o_push_ready,
    output t_blk_item      o_pop_item,
    output logic           o_pop_valid,
    input  wire logic      i_pop_ready
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_blk_item       r_mem [DEPTH];
    logic [AW-1:0]   r_wr_ptr;
    logic [AW-1:0]   r_rd_ptr;
    logic [CW-1:0]   r_count;
    logic [AW-1:0]   n_wr_ptr;
    logic [AW-1:0]   n_rd_ptr;
    logic [CW-1:0]   n_count;
    logic            push;
    logic            pop;

    assign o_push_ready = (r_count != CW'(DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_item   = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    // Advance pointers with wrap at the queue depth
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
        end
        if (push && !pop) begin
            n_count = r_count + CW'(1);
        end else if (pop && !push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Hold storage; write at the tail
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_item;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/sha1c_back.sv =====
// Round engine: one SHA-1 round per cycle unless starved, 16-word schedule line,
// chaining update and digest output register. Depends on sha1c_pkg, sha1c_dig_if.
`default_nettype none
`include "sha1_block_compression_assert.svh"

module sha1c_back import sha1c_pkg::*; (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_word     i_keys [NUM_KEYS],
    input  wire t_blk_item i_item,
    input  wire logic      i_item_valid,
    output logic           o_item_ready,
    sha1c_dig_if.source    o_dig
);

    typedef enum logic [3:0] {
        ST_LOAD  = 4'b0001,
        ST_ROUND = 4'b0010,
        ST_FINAL = 4'b0100,
        ST_EMIT  = 4'b1000
    } t_back_state;

    t_back_state r_state, n_state;
    logic [6:0]  r_round, n_round;
    logic [2:0]  r_emit_idx, n_emit_idx;
    logic        r_out_valid, n_out_valid;
    t_dig_word   r_out;
    t_word       r_chain [NUM_CHAIN];
    t_word       r_w [16];
    t_word       r_a, r_b, r_c, r_d, r_e;

    logic        pop;
    logic        first;
    logic        load_out;
    logic        round_en;
    logic        blk_done;
    logic        sched_start;
    logic        rounds_done;
    logic        out_is_last;
    logic [6:0]  t_num;
    t_word       a_in, b_in, c_in, d_in, e_in;
    t_word       w_in, w_new, f_val, k_val, tmp;

    assign o_item_ready = (r_state == ST_LOAD);
    assign pop          = i_item_valid && o_item_ready;
    assign first        = (r_state == ST_LOAD) && (i_item.idx == WORD_FIRST);
    assign round_en     = pop || (r_state == ST_ROUND);
    assign load_out     = (r_state == ST_EMIT) && (!r_out_valid || o_dig.ready);
    assign blk_done     = pop && (i_item.idx == WORD_LAST);
    assign sched_start  = (r_state == ST_ROUND) && (r_round == ROUND_SCHED);
    assign rounds_done  = (r_state == ST_ROUND) && (r_round == ROUND_LAST);
    assign out_is_last  = (r_out.digest_index == DIG_LAST);

    // Select round inputs: chaining value on a block's first word
    always_comb begin
        if (first) begin
            a_in = i_item.start ? INIT_CHAIN[0] : r_chain[0];
            b_in = i_item.start ? INIT_CHAIN[1] : r_chain[1];
            c_in = i_item.start ? INIT_CHAIN[2] : r_chain[2];
            d_in = i_item.start ? INIT_CHAIN[3] : r_chain[3];
            e_in = i_item.start ? INIT_CHAIN[4] : r_chain[4];
        end else begin
            a_in = r_a;
            b_in = r_b;
            c_in = r_c;
            d_in = r_d;
            e_in = r_e;
        end
        w_new = rotl1(r_w[13] ^ r_w[8] ^ r_w[2] ^ r_w[0]);
        w_in  = (r_state == ST_LOAD) ? i_item.word : w_new;
        t_num = (r_state == ST_LOAD) ? {3'b000, i_item.idx} : r_round;
    end

    // Round function and key by round group
    always_comb begin
        if (t_num < ROUND_B1) begin
            f_val = (b_in & c_in) | (~b_in & d_in);
            k_val = i_keys[0];
        end else if (t_num < ROUND_B2) begin
            f_val = b_in ^ c_in ^ d_in;
            k_val = i_keys[1];
        end else if (t_num < ROUND_B3) begin
            f_val = (b_in & c_in) | (b_in & d_in) | (c_in & d_in);
            k_val = i_keys[2];
        end else begin
            f_val = b_in ^ c_in ^ d_in;
            k_val = i_keys[3];
        end
        tmp = rotl5(a_in) + f_val + e_in + k_val + w_in;
    end

    // Sequence load, rounds, chaining add and emit
    always_comb begin
        n_state     = r_state;
        n_round     = r_round;
        n_emit_idx  = r_emit_idx;
        n_out_valid = r_out_valid;
        if (r_out_valid && o_dig.ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            ST_LOAD: begin
                if (blk_done) begin
                    n_state = ST_ROUND;
                    n_round = ROUND_SCHED;
                end
            end
            ST_ROUND: begin
                n_round = r_round + 7'd1;
                if (r_round == ROUND_LAST) begin
                    n_state = ST_FINAL;
                end
            end
            ST_FINAL: begin
                n_state    = ST_EMIT;
                n_emit_idx = 3'd0;
            end
            ST_EMIT: begin
                if (load_out) begin
                    n_out_valid = 1'b1;
                    n_emit_idx  = r_emit_idx + 3'd1;
                    if (r_emit_idx == DIG_LAST) begin
                        n_state = ST_LOAD;
                    end
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_LOAD;
            r_round     <= '0;
            r_emit_idx  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_round     <= n_round;
            r_emit_idx  <= n_emit_idx;
            r_out_valid <= n_out_valid;
        end
    end

    // Hold the chaining value; reload on start, add working vars after a block
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_CHAIN; i++) begin
                r_chain[i] <= INIT_CHAIN[i];
            end
        end else if (pop && first && i_item.start) begin
            for (int i = 0; i < NUM_CHAIN; i++) begin
                r_chain[i] <= INIT_CHAIN[i];
            end
        end else if (r_state == ST_FINAL) begin
            r_chain[0] <= r_chain[0] + r_a;
            r_chain[1] <= r_chain[1] + r_b;
            r_chain[2] <= r_chain[2] + r_c;
            r_chain[3] <= r_chain[3] + r_d;
            r_chain[4] <= r_chain[4] + r_e;
        end
    end

    // While round_en, advance working vars and schedule line one round per cycle
    always_ff @(posedge i_clk) begin
        if (round_en) begin
            r_a <= tmp;
            r_b <= a_in;
            r_c <= rotl30(b_in);
            r_d <= c_in;
            r_e <= d_in;
            for (int i = 0; i < 15; i++) begin
                r_w[i] <= r_w[i+1];
            end
            r_w[15] <= w_in;
        end
    end

    // Load the output register with the next digest word
    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out.digest_word  <= r_chain[r_emit_idx];
            r_out.digest_index <= r_emit_idx;
            r_out.digest_last  <= (r_emit_idx == DIG_LAST);
        end
    end

    assign o_dig.valid = r_out_valid;
    assign o_dig.data  = r_out;

    `SHA1C_ASSERT_NEXT(a_block_starts_rounds, blk_done, sched_start)
    `SHA1C_ASSERT_NEXT(a_rounds_end_in_final, rounds_done, r_state == ST_FINAL)
    `SHA1C_ASSERT_NOW(a_digest_index_range, r_out_valid, r_out.digest_index <= DIG_LAST)
    `SHA1C_ASSERT_NOW(a_last_on_final_word, r_out_valid, r_out.digest_last == out_is_last)

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking bench for sha1_block_compression: feeds directed and random words,
// predicts every five-word digest, checks each digest word and the key readback.
// Depends on sha1c_pkg, the stream interfaces and the compression top level.

module testbench;
    import sha1c_pkg::*;

    localparam int CLK_HALF    = 4;
    localparam int SETTLE_CYC  = 120;
    localparam int CYCLE_LIMIT = 200000;
    localparam int KEY_STRIDE  = 4;
    localparam int BLK_WORDS   = WORD_LAST + 1;
    localparam int PHASE_WORDS = 30;
    localparam int DIR_ROWS    = 23;

    // One directed word; known marks the row whose digest is typed in below
    typedef struct packed {
        t_word word;
        logic  start;
        logic  known;
    } t_stim_row;

    // Standard digest of the message "abc"
    localparam t_word ABC_DIGEST [NUM_CHAIN] = '{
        32'hA9993E36, 32'h4706816A, 32'hBA3E2571, 32'h7850C26C, 32'h9CD0D89D
    };

    // Padded "abc" block sent with no start flag, so it chains from the reset
    // value; then a start on a block boundary, a start mid-block, word extremes
    localparam t_stim_row DIR_TABLE [DIR_ROWS] = '{
        '{32'h61626380, 1'b0, 1'b0},
        '{32'h00000000, 1'b0, 1'b0},
        '{32'h00000000, 1'b0, 1'b0},
        '{32'h00000000, 1'b0, 1'b0},
        '{32'h00000000, 1'b0, 1'b0},
        '{32'h00000000, 1'b0, 1'b0},
        '{32'h00000000, 1'b0, 1'b0},
        '{32'h00000000, 1'b0, 1'b0},
        '{32'h00000000, 1'b0, 1'b0},
        '{32'h00000000, 1'b0, 1'b0},
        '{32'h00000000, 1'b0, 1'b0},
        '{32'h00000000, 1'b0, 1'b0},
        '{32'h00000000, 1'b0, 1'b0},
        '{32'h00000000, 1'b0, 1'b0},
        '{32'h00000000, 1'b0, 1'b0},
        '{32'h00000018, 1'b0, 1'b1},
        '{32'hFFFFFFFF, 1'b1, 1'b0},
        '{32'h00000000, 1'b0, 1'b0},
        '{32'h80000000, 1'b0, 1'b0},
        '{32'h00000001, 1'b1, 1'b0},
        '{32'h7FFFFFFF, 1'b0, 1'b0},
        '{32'hFFFFFFFF, 1'b0, 1'b0},
        '{32'hA5A5A5A5, 1'b0, 1'b0}
    };

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    t_word                 pwdata;
    t_word                 prdata;
    logic                  pready;

    sha1c_msg_if msg_if ();
    sha1c_dig_if dig_if ();

    // Predictor state: chaining value, keys, schedule window, word position
    t_word      chain_val [NUM_CHAIN];
    t_word      key_val   [NUM_KEYS];
    t_word      key_plan  [NUM_KEYS];
    t_word      sched_win [BLK_WORDS];
    logic [3:0] blk_words;
    t_dig_word  pending_digest [$];
    t_dig_word  dig_want;

    int n_fail     = 0;
    int n_cycles   = 0;
    int stall_left = 0;
    bit idle_en    = 1'b1;

    sha1_block_compression DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_msg   (msg_if),
        .o_dig   (dig_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    // Run the 80 rounds over the schedule window and fold into the chaining value
    function automatic void sha1_rounds();
        t_word a, b, c, d, e, f, k, w, tmp;
        int    slot;
        a = chain_val[0];
        b = chain_val[1];
        c = chain_val[2];
        d = chain_val[3];
        e = chain_val[4];
        for (int t = 0; t <= ROUND_LAST; t++) begin
            slot = t % BLK_WORDS;
            // Roll the schedule forward once the message words are used up
            if (t >= ROUND_SCHED) begin
                w = sched_win[(t + 13) % BLK_WORDS] ^ sched_win[(t + 8) % BLK_WORDS]
                  ^ sched_win[(t + 2) % BLK_WORDS] ^ sched_win[slot];
                sched_win[slot] = {w[30:0], w[31]};
            end
            if (t < ROUND_B1) begin
                f = (b & c) | (~b & d);
                k = key_val[0];
            end else if (t < ROUND_B2) begin
                f = b ^ c ^ d;
                k = key_val[1];
            end else if (t < ROUND_B3) begin
                f = (b & c) | (b & d) | (c & d);
                k = key_val[2];
            end else begin
                f = b ^ c ^ d;
                k = key_val[3];
            end
            tmp = {a[26:0], a[31:27]} + f + e + k + sched_win[slot];
            e = d;
            d = c;
            c = {b[1:0], b[31:2]};
            b = a;
            a = tmp;
        end
        chain_val[0] += a;
        chain_val[1] += b;
        chain_val[2] += c;
        chain_val[3] += d;
        chain_val[4] += e;
    endfunction

    // Take one accepted word; queue five digest words when a block completes
    function automatic void sha1_absorb_word(input t_word w, input logic s, input logic known);
        t_dig_word dw;
        if (s) begin
            chain_val = INIT_CHAIN;
            blk_words = WORD_FIRST;
        end
        sched_win[blk_words] = w;
        blk_words = blk_words + 1'b1;
        if (blk_words == WORD_FIRST) begin
            sha1_rounds();
            for (int i = 0; i < NUM_CHAIN; i++) begin
                dw.digest_word  = known ? ABC_DIGEST[i] : chain_val[i];
                dw.digest_index = 3'(i);
                dw.digest_last  = (3'(i) == DIG_LAST);
                pending_digest.push_back(dw);
            end
        end
    endfunction

    // Present one message word after an optional gap and hold it until taken
    task automatic send_word(input t_word w, input logic s, input logic known);
        int gap;
        gap = (idle_en && $urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
        if (gap != 0) begin
            @(negedge i_clk);
            msg_if.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        msg_if.valid <= 1'b1;
        msg_if.data  <= '{message_word: w, start_message: s};
        @(posedge i_clk);
        while (!msg_if.ready) @(posedge i_clk);
        sha1_absorb_word(w, s, known);
    endtask

    // Mostly whole messages of one to three blocks; now and then a stray fragment
    task automatic send_messages(input int n_words);
        int sent;
        int frag;
        int blocks;
        sent = 0;
        while (sent < n_words) begin
            if ($urandom_range(0, 4) == 0) begin
                frag = $urandom_range(1, BLK_WORDS - 1);
                for (int i = 0; i < frag; i++)
                    send_word($urandom, (i == 0) && ($urandom_range(0, 1) == 1), 1'b0);
                sent += frag;
            end
            blocks = $urandom_range(1, 3);
            for (int i = 0; i < blocks * BLK_WORDS; i++)
                send_word($urandom, i == 0, 1'b0);
            sent += blocks * BLK_WORDS;
        end
    endtask

    // Drop valid, wait for every digest word, then let the engine settle
    task automatic drain();
        @(negedge i_clk);
        msg_if.valid <= 1'b0;
        while (pending_digest.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    // APB transfer: setup cycle, access cycle, complete on pready
    task automatic apb_access(input int r, input logic wr, input t_word v);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= APB_ADDR_W'(r * KEY_STRIDE);
        pwdata  <= v;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (wr) begin
            key_val[r] = v;
        end else if (prdata !== key_val[r]) begin
            $error("round_key_%0d: expected %h, actual %h", r, key_val[r], prdata);
            n_fail++;
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Write the planned keys, then read all of them back
    task automatic load_keys();
        for (int r = 0; r < NUM_KEYS; r++) apb_access(r, 1'b1, key_plan[r]);
        for (int r = 0; r < NUM_KEYS; r++) apb_access(r, 1'b0, '0);
    endtask

    // Stall the digest channel in short random bursts
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            dig_if.ready <= 1'b0;
            stall_left   <= stall_left - 1;
        end else if (idle_en && $urandom_range(0, 4) == 0) begin
            dig_if.ready <= 1'b0;
            stall_left   <= $urandom_range(0, 2);
        end else begin
            dig_if.ready <= 1'b1;
        end
    end

    // Check each digest word against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && dig_if.valid && dig_if.ready) begin
            if (pending_digest.size() == 0) begin
                $error("digest word %h with nothing pending", dig_if.data.digest_word);
                n_fail++;
            end else begin
                dig_want = pending_digest.pop_front();
                if (dig_if.data.digest_word !== dig_want.digest_word) begin
                    $error("digest_word: expected %h, actual %h",
                           dig_want.digest_word, dig_if.data.digest_word);
                    n_fail++;
                end
                if (dig_if.data.digest_index !== dig_want.digest_index) begin
                    $error("digest_index: expected %0d, actual %0d",
                           dig_want.digest_index, dig_if.data.digest_index);
                    n_fail++;
                end
                if (dig_if.data.digest_last !== dig_want.digest_last) begin
                    $error("digest_last: expected %b, actual %b",
                           dig_want.digest_last, dig_if.data.digest_last);
                    n_fail++;
                end
            end
        end
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        n_cycles++;
        if (n_cycles > CYCLE_LIMIT) begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    initial begin
        i_rst_n      = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        msg_if.valid = 1'b0;
        msg_if.data  = '0;
        chain_val    = INIT_CHAIN;
        key_val      = KEY_RESET;
        blk_words    = WORD_FIRST;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset values of the keys
        for (int r = 0; r < NUM_KEYS; r++) apb_access(r, 1'b0, '0);

        // Directed words, then random messages on the standard keys
        for (int r = 0; r < DIR_ROWS; r++)
            send_word(DIR_TABLE[r].word, DIR_TABLE[r].start, DIR_TABLE[r].known);
        send_messages(PHASE_WORDS);
        drain();

        // All keys cleared
        key_plan = '{default: '0};
        load_keys();
        send_messages(PHASE_WORDS);
        drain();

        // All keys set
        key_plan = '{default: '1};
        load_keys();
        send_messages(PHASE_WORDS);
        drain();

        // Random keys
        for (int r = 0; r < NUM_KEYS; r++) key_plan[r] = $urandom;
        load_keys();
        send_messages(PHASE_WORDS);
        drain();

        // Standard keys again, both channels at full rate
        idle_en  = 1'b0;
        key_plan = KEY_RESET;
        load_keys();
        send_messages(PHASE_WORDS);
        drain();

        if (n_fail == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/sha1c_pkg.sv
hw/rtl/sha1c_stream_if.sv
hw/rtl/sha1c_front.sv
hw/rtl/sha1c_queue.sv
hw/rtl/sha1c_back.sv
hw/rtl/sha1_block_compression.sv
sim/testbench.sv
